// File: hdl/afs_pkg.sv
// ---------------------------------------------------------------------------
// afs_pkg
// Shared types, codes and the frame delay selection for the animation frame
// sequencer.
// ---------------------------------------------------------------------------
package afs_pkg;

   localparam int FrameW = 6;
   localparam int DelayW = 16;

   localparam logic [DelayW-1:0] DEFAULT_DELAY = 16'd100;
   localparam logic [DelayW-1:0] ELAPSED_MAX   = 16'hFFFF;

   // item kinds
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_BASE  = 3'd1;
   localparam logic [2:0] KIND_OVR   = 3'd2;
   localparam logic [2:0] KIND_START = 3'd3;
   localparam logic [2:0] KIND_STOP  = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [1:0] CSR_GLOBAL_DLY  = 2'd1;
   localparam logic [1:0] CSR_LAST_DLY    = 2'd2;

   typedef struct packed {
      logic [2:0]        kind;
      logic [4:0]        frame_slot;
      logic [DelayW-1:0] delay_ms;
   } afs_req_type;

   typedef struct packed {
      logic [4:0]        frame_index;
      logic              show_frame;
      logic              clear_display;
      logic              playing;
      logic [DelayW-1:0] current_delay;
   } afs_rsp_type;

   // result fields known when the item is taken
   typedef struct packed {
      logic [FrameW-1:0] frame;
      logic              show;
      logic              clear;
      logic              playing;
   } afs_pend_type;

   // everything the delay selection needs besides the frame number
   typedef struct packed {
      logic [FrameW-1:0] count;
      logic [DelayW-1:0] glob;
      logic [DelayW-1:0] last;
      logic [DelayW-1:0] base;
      logic [DelayW-1:0] ovr;
   } afs_view_type;

   function automatic logic [DelayW-1:0] frame_delay(input logic [FrameW-1:0] frame,
                                                     input afs_view_type  v);
      logic [DelayW-1:0] d;
      if (frame >= v.count) begin
         d = DEFAULT_DELAY;
      end else if ((frame == (v.count - 6'd1)) && (v.last != '0)) begin
         d = v.last;
      end else if (v.ovr != '0) begin
         d = v.ovr;
      end else if (v.glob != '0) begin
         d = v.glob;
      end else begin
         d = v.base;
      end
      return d;
   endfunction

endpackage

// File: hdl/animation_frame_sequencer_top.sv
// ---------------------------------------------------------------------------
// animation_frame_sequencer_top
// Millisecond frame timer for an animation: delay tables, start/stop and
// frame advance, one result item per input item.
// ---------------------------------------------------------------------------
// Path: pending stage (state update), then output register (delay selection
//   once the delay RAMs return the new frame's entries).
// Throughput: 1 item per cycle; while a result waits on rsp_stall the pending
//   stage takes one more item, after which req_stall follows rsp_stall.
// Reset: synchronous; registers to 0, frame 0, stopped; tables read as
//   100 (base) and 0 (override) through per-entry valid bits, no sweep.
// ---------------------------------------------------------------------------
module animation_frame_sequencer_top #(
   parameter int MAX_FRAMES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  afs_pkg::afs_req_type req_payload,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output afs_pkg::afs_rsp_type rsp_payload,
   // register writes
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import afs_pkg::*;

   afs_pend_type pend;
   afs_view_type view;
   logic         busy;
   logic         accept;

   // hold off items during reset and while the pending stage cannot drain
   assign req_stall = reset || busy;
   assign accept    = req_valid && !req_stall;

   // core: state update and table access happen in the cycle of acceptance
   afs_core #(.MAX_FRAMES(MAX_FRAMES)) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pend      (pend),
      .view      (view)
   );

   // result side: the view matches the pending item's frame in the next cycle
   afs_rsp u_rsp (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pend        (pend),
      .view        (view),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hdl/afs_ram.sv
// ---------------------------------------------------------------------------
// afs_ram
// Generic single write port RAM, registered read, old data on a collision.
// ---------------------------------------------------------------------------
module afs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/afs_core.sv
// ---------------------------------------------------------------------------
// afs_core
// Playback state, delay tables and configuration registers. Keeps the table
// entries of the current frame ready for the delay selection.
// ---------------------------------------------------------------------------
module afs_core #(
   parameter int MAX_FRAMES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  afs_pkg::afs_req_type req,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   output afs_pkg::afs_pend_type pend,
   output afs_pkg::afs_view_type view
);
   import afs_pkg::*;

   localparam int AW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CntCap = (MAX_FRAMES < 63) ? MAX_FRAMES : 63;
   localparam logic [8:0]        MaxSlots = 9'(MAX_FRAMES);
   localparam logic [FrameW-1:0] CountCap = 6'(CntCap);

   logic [FrameW-1:0] frame_count_ff;
   logic [DelayW-1:0] glob_ff, last_ff;

   logic [FrameW-1:0] frame_ff, frame_in;
   logic [DelayW-1:0] elapsed_ff, elapsed_in;
   logic              running_ff, running_in;

   logic [MAX_FRAMES-1:0] vld_b_ff, vld_o_ff;
   logic                  rdv_b_ff, rdv_b_in, rdv_o_ff, rdv_o_in;
   logic                  byp_b_ff, byp_b_in, byp_o_ff, byp_o_in;
   logic [DelayW-1:0]     bypd_b_ff, bypd_o_ff;

   logic [FrameW-1:0] count;
   logic [DelayW-1:0] ram_b_q, ram_o_q, cur_delay, tick_elapsed;
   logic [FrameW:0]   frame_inc;
   logic [8:0]        slot_w, frame_w;
   logic [AW-1:0]     waddr, raddr;
   logic              we_b, we_o, show, clear;

   assign count = (frame_count_ff > CountCap) ? CountCap : frame_count_ff;

   // table entries of the current frame: bypass, then RAM, then reset value
   assign view.count = count;
   assign view.glob  = glob_ff;
   assign view.last  = last_ff;
   assign view.base  = byp_b_ff ? bypd_b_ff : (rdv_b_ff ? ram_b_q : DEFAULT_DELAY);
   assign view.ovr   = byp_o_ff ? bypd_o_ff : (rdv_o_ff ? ram_o_q : '0);

   assign cur_delay    = frame_delay(frame_ff, view);
   assign tick_elapsed = (elapsed_ff != ELAPSED_MAX) ? (elapsed_ff + 16'd1) : elapsed_ff;
   assign frame_inc    = {1'b0, frame_ff} + 7'd1;

   assign slot_w = {4'b0, req.frame_slot};
   assign waddr  = slot_w[AW-1:0];

   always_comb begin
      frame_in   = frame_ff;
      elapsed_in = elapsed_ff;
      running_in = running_ff;
      show       = 1'b0;
      clear      = 1'b0;
      we_b       = 1'b0;
      we_o       = 1'b0;
      if (accept) begin
         unique case (req.kind)
            KIND_TICK: begin
               if (running_ff && (count != '0)) begin
                  elapsed_in = tick_elapsed;
                  if (tick_elapsed >= cur_delay) begin
                     frame_in   = (frame_inc >= {1'b0, count}) ? '0 : frame_inc[FrameW-1:0];
                     elapsed_in = '0;
                     show       = 1'b1;
                  end
               end
            end
            KIND_BASE: we_b = (slot_w < MaxSlots);
            KIND_OVR:  we_o = ({1'b0, req.frame_slot} < count);
            KIND_START: begin
               if (count != '0) begin
                  frame_in   = '0;
                  elapsed_in = '0;
                  running_in = 1'b1;
                  show       = 1'b1;
               end
            end
            KIND_STOP: begin
               running_in = 1'b0;
               clear      = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // read address follows the frame of the next cycle
   assign frame_w  = {3'b0, frame_in};
   assign raddr    = frame_w[AW-1:0];
   assign byp_b_in = we_b && (waddr == raddr);
   assign byp_o_in = we_o && (waddr == raddr);
   assign rdv_b_in = vld_b_ff[raddr] || byp_b_in;
   assign rdv_o_in = vld_o_ff[raddr] || byp_o_in;

   afs_ram #(.WIDTH(DelayW), .DEPTH(MAX_FRAMES)) u_base_ram (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (req.delay_ms),
      .raddr (raddr),
      .rdata (ram_b_q)
   );

   afs_ram #(.WIDTH(DelayW), .DEPTH(MAX_FRAMES)) u_ovr_ram (
      .clock (clock),
      .we    (we_o),
      .waddr (waddr),
      .wdata (req.delay_ms),
      .raddr (raddr),
      .rdata (ram_o_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         glob_ff        <= '0;
         last_ff        <= '0;
         frame_ff       <= '0;
         elapsed_ff     <= '0;
         running_ff     <= 1'b0;
         vld_b_ff       <= '0;
         vld_o_ff       <= '0;
         rdv_b_ff       <= 1'b0;
         rdv_o_ff       <= 1'b0;
         byp_b_ff       <= 1'b0;
         byp_o_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_COUNT: frame_count_ff <= csr_wdata[FrameW-1:0];
               CSR_GLOBAL_DLY:  glob_ff        <= csr_wdata;
               CSR_LAST_DLY:    last_ff        <= csr_wdata;
               default: ;
            endcase
         end
         frame_ff   <= frame_in;
         elapsed_ff <= elapsed_in;
         running_ff <= running_in;
         if (we_b) begin
            vld_b_ff[waddr] <= 1'b1;
         end
         if (we_o) begin
            vld_o_ff[waddr] <= 1'b1;
         end
         rdv_b_ff <= rdv_b_in;
         rdv_o_ff <= rdv_o_in;
         byp_b_ff <= byp_b_in;
         byp_o_ff <= byp_o_in;
      end
   end

   always_ff @(posedge clock) begin
      bypd_b_ff <= req.delay_ms;
      bypd_o_ff <= req.delay_ms;
   end

   assign pend.frame   = frame_in;
   assign pend.show    = show;
   assign pend.clear   = clear;
   assign pend.playing = running_in;

endmodule

// File: hdl/afs_rsp.sv
// ---------------------------------------------------------------------------
// afs_rsp
// Pending stage and output register; adds the effective delay once the table
// entries of the new frame are read.
// ---------------------------------------------------------------------------
module afs_rsp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  afs_pkg::afs_pend_type pend,
   input  afs_pkg::afs_view_type view,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output afs_pkg::afs_rsp_type  rsp_payload
);
   import afs_pkg::*;

   logic         p_vld_ff, p_vld_in;
   afs_pend_type p_ff;
   logic         o_vld_ff, o_vld_in;
   afs_rsp_type  o_ff, o_in;
   logic         o_load, p_adv;

   assign o_load = !o_vld_ff || !rsp_stall;
   assign p_adv  = p_vld_ff && o_load;
   assign busy   = p_vld_ff && !o_load;

   assign p_vld_in = accept || (p_vld_ff && !o_load);
   assign o_vld_in = o_load ? p_vld_ff : o_vld_ff;

   always_comb begin
      o_in.frame_index   = p_ff.frame[4:0];
      o_in.show_frame    = p_ff.show;
      o_in.clear_display = p_ff.clear;
      o_in.playing       = p_ff.playing;
      o_in.current_delay = frame_delay(p_ff.frame, view);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= p_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_ff <= pend;
      end
      if (p_adv) begin
         o_ff <= o_in;
      end
   end

   assign rsp_valid   = o_vld_ff;
   assign rsp_payload = o_ff;

endmodule

// File: bench/animation_frame_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// animation_frame_sequencer_top_tb
// Self-checking bench for the animation frame timer. A scoreboard class
// predicts each result item from every accepted input item. Directed items
// come first, then random playback sequences under several register
// settings and idling patterns, with one long receiver hold-off.
// ---------------------------------------------------------------------------
import afs_pkg::*;

class frame_sequence_scoreboard;
   localparam int TableDepth = 32;

   // predicted block state
   logic [15:0] base_tbl [TableDepth];
   logic [15:0] ovr_tbl [TableDepth];
   logic [4:0]  frame;
   logic [15:0] elapsed;
   bit          running;
   logic [5:0]  count_reg;
   logic [15:0] glob_reg;
   logic [15:0] last_reg;

   afs_rsp_type reports_due[$];

   int errors;
   int results_checked;
   int shows;
   int wraps;
   int top_frame;

   function new();
      errors = 0;
      results_checked = 0;
      shows = 0;
      wraps = 0;
      top_frame = 0;
      for (int i = 0; i < TableDepth; i++) begin
         base_tbl[i] = DEFAULT_DELAY;
         ovr_tbl[i]  = '0;
      end
      frame     = '0;
      elapsed   = '0;
      running   = 1'b0;
      count_reg = '0;
      glob_reg  = '0;
      last_reg  = '0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
         CSR_FRAME_COUNT: count_reg = val[5:0];
         CSR_GLOBAL_DLY:  glob_reg  = val;
         CSR_LAST_DLY:    last_reg  = val;
         default: ;
      endcase
   endfunction

   function int eff_count();
      return (count_reg > TableDepth) ? TableDepth : int'(count_reg);
   endfunction

   // delay of the current frame, by priority
   function logic [15:0] selected_delay();
      int n;
      n = eff_count();
      if (int'(frame) >= n) return DEFAULT_DELAY;
      if (int'(frame) == n - 1 && last_reg != '0) return last_reg;
      if (ovr_tbl[frame] != '0) return ovr_tbl[frame];
      if (glob_reg != '0) return glob_reg;
      return base_tbl[frame];
   endfunction

   // apply one accepted item and queue the result it causes
   function void step_timer(afs_req_type item);
      afs_rsp_type due;
      int          n;
      int          nxt;
      logic [15:0] d;
      bit          show;
      bit          clr;
      n    = eff_count();
      show = 1'b0;
      clr  = 1'b0;
      case (item.kind)
         KIND_TICK: begin
            if (running && n > 0) begin
               d = selected_delay();
               if (elapsed != ELAPSED_MAX) elapsed = elapsed + 16'd1;
               if (elapsed >= d) begin
                  nxt = int'(frame) + 1;
                  if (nxt >= n) begin
                     frame = '0;
                     wraps++;
                  end else begin
                     frame = nxt[4:0];
                  end
                  elapsed = '0;
                  show = 1'b1;
               end
            end
         end
         KIND_BASE: base_tbl[item.frame_slot] = item.delay_ms;
         KIND_OVR: begin
            if (int'(item.frame_slot) < n) ovr_tbl[item.frame_slot] = item.delay_ms;
         end
         KIND_START: begin
            if (n > 0) begin
               frame   = '0;
               elapsed = '0;
               running = 1'b1;
               show    = 1'b1;
            end
         end
         KIND_STOP: begin
            running = 1'b0;
            clr     = 1'b1;
         end
         default: ;
      endcase
      if (show) shows++;
      if (int'(frame) > top_frame) top_frame = int'(frame);
      due.frame_index   = frame;
      due.show_frame    = show;
      due.clear_display = clr;
      due.playing       = running;
      due.current_delay = selected_delay();
      reports_due.push_back(due);
   endfunction

   task report(string what, int got, int want);
      errors++;
      $display("%0t mismatch on result %0d: %s got %0d expected %0d",
               $time, results_checked, what, got, want);
   endtask

   task check_result(afs_rsp_type got);
      afs_rsp_type want;
      if (reports_due.size() == 0) begin
         report("result with nothing due, frame", got.frame_index, 0);
         return;
      end
      want = reports_due.pop_front();
      if (got.frame_index !== want.frame_index)
         report("frame_index", got.frame_index, want.frame_index);
      if (got.show_frame !== want.show_frame)
         report("show_frame", got.show_frame, want.show_frame);
      if (got.clear_display !== want.clear_display)
         report("clear_display", got.clear_display, want.clear_display);
      if (got.playing !== want.playing)
         report("playing", got.playing, want.playing);
      if (got.current_delay !== want.current_delay)
         report("current_delay", got.current_delay, want.current_delay);
      results_checked++;
   endtask
endclass

module animation_frame_sequencer_top_tb;

   // kinds and register index outside the decoded set
   localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
   localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;
   localparam logic [1:0] CSR_SPARE       = 2'd3;

   localparam int Segments     = 16;
   localparam int SegmentItems = 112;
   localparam int HoldCycles   = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   afs_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   afs_rsp_type rsp_payload;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   frame_sequence_scoreboard sb = new();

   // idling knobs, in percent; hold_left is a forced receiver stall in cycles
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int settings_used = 0;

   animation_frame_sequencer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, or a long counted hold-off when asked for.
   // Driven at the falling edge so the block sees a settled value.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // Both handshakes sampled at the rising edge, before the block's own
   // register updates land, so the values seen are those the block used.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.step_timer(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      end
   end

   // Enter and leave at a falling edge. Valid is left high after the item
   // goes in; the next call either replaces the payload or idles.
   task automatic send(input logic [2:0] kind, input logic [4:0] slot,
                       input logic [15:0] dly);
      afs_req_type item;
      item.kind       = kind;
      item.frame_slot = slot;
      item.delay_ms   = dly;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait for every due result, then let the two-stage pipe settle
   task automatic drain();
      req_valid = 1'b0;
      while (sb.reports_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly short delays so frames actually advance; now and then the extremes
   function automatic logic [15:0] pick_delay();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'd0;
      if (r < 80) return 16'($urandom_range(6, 1));
      if (r < 90) return 16'($urandom_range(40, 7));
      if (r < 95) return 16'hFFFF;
      return 16'($urandom_range(65535));
   endfunction

   // slot within the loaded frames most of the time
   function automatic logic [4:0] pick_slot();
      int n;
      n = sb.eff_count();
      if (n > 0 && $urandom_range(3) != 0) return 5'($urandom_range(n - 1));
      return 5'($urandom_range(31));
   endfunction

   task automatic set_registers(input logic [5:0] cnt, input logic [15:0] glob,
                                input logic [15:0] last);
      // upper bits of the count write are don't-care: exercise them anyway
      write_reg(CSR_FRAME_COUNT, {10'($urandom_range(1023)), cnt});
      write_reg(CSR_GLOBAL_DLY, glob);
      write_reg(CSR_LAST_DLY, last);
      if ($urandom_range(2) == 0) write_reg(CSR_SPARE, 16'($urandom_range(65535)));
      settings_used++;
   endtask

   // well-formed playback: load some delays, start, then mostly ticks with
   // table writes, restarts, stops and the odd unused kind mixed in
   task automatic run_playback(input int n_items);
      logic [2:0] kind;
      int         r;
      repeat ($urandom_range(5, 2)) send(KIND_BASE, pick_slot(), pick_delay());
      repeat ($urandom_range(3, 1)) send(KIND_OVR, pick_slot(), pick_delay());
      send(KIND_START, 5'($urandom_range(31)), 16'($urandom_range(65535)));
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(99);
         if (r < 66)      kind = KIND_TICK;
         else if (r < 75) kind = KIND_BASE;
         else if (r < 84) kind = KIND_OVR;
         else if (r < 88) kind = KIND_START;
         else if (r < 92) kind = KIND_STOP;
         else if (r < 95) kind = 3'($urandom_range(KIND_RSVD_LAST, KIND_RSVD_FIRST));
         else             kind = KIND_TICK;
         // do not sit stopped for long
         if (!sb.running && $urandom_range(4) == 0) kind = KIND_START;
         if (kind == KIND_BASE || kind == KIND_OVR)
            send(kind, pick_slot(), pick_delay());
         else
            send(kind, 5'($urandom_range(31)), 16'($urandom_range(65535)));
      end
   endtask

   initial begin
      int          r;
      logic [5:0]  cnt;
      logic [15:0] glob;
      logic [15:0] last;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_FRAME_COUNT;
      csr_wdata   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed: no frames loaded, all registers at reset value ---
      send(KIND_TICK, 5'd0, 16'd0);           // tick while stopped
      send(KIND_STOP, 5'd5, 16'hFFFF);        // stop when already idle
      send(KIND_START, 5'd31, 16'd0);         // start with no frames: ignored
      send(KIND_OVR, 5'd0, 16'h1234);         // override beyond count: ignored
      send(KIND_RSVD_FIRST, 5'd31, 16'hFFFF); // unused kinds
      send(KIND_RSVD_LAST, 5'd0, 16'd0);
      send(KIND_BASE, 5'd31, 16'hFFFF);
      send(KIND_BASE, 5'd0, 16'd1);
      send(KIND_BASE, 5'd1, 16'd0);           // zero delay on frame 1
      drain();

      // count above the table size clamps to the table
      set_registers(6'd63, 16'd0, 16'd0);
      send(KIND_OVR, 5'd31, 16'd2);
      send(KIND_START, 5'd0, 16'd0);
      send(KIND_TICK, 5'd0, 16'd0);           // frame 0, delay 1: advance
      send(KIND_TICK, 5'd0, 16'd0);           // frame 1, delay 0: advance
      send(KIND_TICK, 5'd0, 16'd0);
      send(KIND_START, 5'd0, 16'd0);          // restart while playing
      send(KIND_STOP, 5'd0, 16'd0);
      drain();

      // two frames, last-frame and global overrides in play
      set_registers(6'd2, 16'hFFFF, 16'd3);
      send(KIND_OVR, 5'd0, 16'd1);
      send(KIND_OVR, 5'd2, 16'd9);            // slot at count: ignored
      send(KIND_START, 5'd0, 16'd0);
      repeat (5) send(KIND_TICK, 5'd0, 16'd0); // through the wrap and on to frame 1
      drain();
      set_registers(6'd1, 16'hFFFF, 16'd3);   // current frame now beyond count
      send(KIND_TICK, 5'd0, 16'd0);
      drain();
      set_registers(6'd0, 16'd0, 16'd0);      // running with nothing loaded
      send(KIND_TICK, 5'd0, 16'd0);
      drain();

      // --- random playback, four idling patterns of four settings each ---
      for (int seg = 0; seg < Segments; seg++) begin
         case (seg / 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         r    = $urandom_range(99);
         cnt  = (r < 10) ? 6'd0 : (r < 20) ? 6'd32 : (r < 30) ? 6'($urandom_range(63, 33)) :
                6'($urandom_range(12, 1));
         glob = ($urandom_range(1) == 0) ? 16'd0 : pick_delay();
         last = ($urandom_range(1) == 0) ? 16'd0 : pick_delay();
         // make sure the extremes come round in every idling pattern
         case (seg % 4)
            1: begin cnt = 6'd32; glob = 16'd0;    last = 16'hFFFF; end
            2: begin cnt = 6'd1;  glob = 16'hFFFF; last = 16'd0;    end
            3: cnt = 6'd0;
            default: ;
         endcase
         set_registers(cnt, glob, last);
         // back-pressure: the receiver holds off while items keep coming
         if (seg == 0) hold_left = HoldCycles;
         run_playback(SegmentItems);
         drain();
      end

      $display("covered %0d results over %0d register settings and four idling patterns",
               sb.results_checked, settings_used);
      $display("%0d frame shows, %0d wraps to frame 0, highest frame reached %0d",
               sb.shows, sb.wraps, sb.top_frame);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout waiting for the block");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: animation_frame_sequencer_top.f
hdl/afs_pkg.sv
hdl/afs_ram.sv
hdl/afs_core.sv
hdl/afs_rsp.sv
hdl/animation_frame_sequencer_top.sv
bench/animation_frame_sequencer_top_tb.sv
